// ----- rtl/core/pid_with_feedforward_offset_assert.svh -----
// assertion macros for the pid controller with feedforward offset
// used by the top level only; expects aclk and aresetn in scope
`ifndef PID_WITH_FEEDFORWARD_OFFSET_ASSERT_SVH
`define PID_WITH_FEEDFORWARD_OFFSET_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PIDFF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PIDFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pidff_pkg.sv -----
// types and constants of the pid controller with feedforward offset
// no dependencies
package pidff_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_SETPOINT  = 3'd0;
    localparam cfg_index_t REG_KP        = 3'd1;
    localparam cfg_index_t REG_KI_STEP   = 3'd2;
    localparam cfg_index_t REG_KD_RATE   = 3'd3;
    localparam cfg_index_t REG_FF_OFFSET = 3'd4;

    // datapath widths
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ERR_W  = 33;
    localparam int unsigned DIFF_W = 34;
    localparam int unsigned SUM_W  = 48;
    localparam int unsigned ACC_W  = 82;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // saturation limits
    localparam sum_t  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam sum_t  SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam data_t DRIVE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DRIVE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ----- rtl/core/pid_with_feedforward_offset.sv -----
// pid controller with feedforward offset, signed q16.16, five-stage pipeline
// depends on pidff_pkg and pid_with_feedforward_offset_assert.svh
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+---------------------------------
// s_       | in  | s_valid / s_ready  | s_measured_value
// m_       | out | m_valid / m_ready  | m_drive_value, m_saturated
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one item per clock sustained while m_ready is high; an item passes the
// a, b, c and d registers before m_valid rises. the per-item state loop is
// one 48-bit add and saturate in the error stage. the integral product is
// split into 32x24 and 32x25 partial products, the other two are 32x33 and 32x34.
// each stage holds its item while the next stage is full and stalled, so
// empty stages keep filling while a result waits on m_ready.
// aresetn clears the valids, the configuration registers, the error sum and
// the last error and sets the first-sample flag.
`include "pid_with_feedforward_offset_assert.svh"

module pid_with_feedforward_offset (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_measured_value,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_drive_value,
    output logic                          m_saturated,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pidff_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    // configuration registers
    pidff_pkg::data_t setpoint_reg, kp_reg, ki_step_reg, kd_rate_reg, ff_offset_reg;

    // controller state
    pidff_pkg::sum_t  error_sum_reg, error_sum_next;
    pidff_pkg::err_t  last_error_reg;
    logic             first_sample_reg;

    // pipeline valids
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;
    logic a_valid_next, b_valid_next, c_valid_next, d_valid_next, m_valid_next;
    logic b_rdy, c_rdy, d_rdy, e_rdy;
    logic a_load, b_load, c_load, d_load, e_load;

    // stage payloads
    pidff_pkg::data_t a_meas_reg;
    pidff_pkg::err_t  b_err_reg, b_err_next;
    pidff_pkg::diff_t b_diff_reg, b_diff_next;
    pidff_pkg::sum_t  b_sum_reg;
    logic             b_sat_reg, b_sat_next;
    logic signed [64:0] c_pkp_reg, c_pkp_next;
    logic signed [65:0] c_pkd_reg, c_pkd_next;
    logic signed [55:0] c_pkih_reg, c_pkih_next;
    logic signed [56:0] c_pkil_reg, c_pkil_next;
    logic             c_sat_reg;
    pidff_pkg::acc_t  d_s1_reg, d_s1_next, d_s2_reg, d_s2_next;
    logic             d_sat_reg;
    pidff_pkg::data_t m_drive_reg, m_drive_next;
    logic             m_sat_reg, m_sat_next;

    // stage b combinational
    logic signed [pidff_pkg::SUM_W:0] sum_wide;
    logic                              sum_ovf;
    // stage e combinational
    pidff_pkg::acc_t acc;
    logic            acc_in_range;

    // handshake chain: a stage takes an item when empty or when it moves on
    assign e_rdy   = !m_valid_reg || m_ready;
    assign d_rdy   = !d_valid_reg || e_rdy;
    assign c_rdy   = !c_valid_reg || d_rdy;
    assign b_rdy   = !b_valid_reg || c_rdy;
    assign s_ready = !a_valid_reg || b_rdy;

    assign a_load = s_valid && s_ready;
    assign b_load = a_valid_reg && b_rdy;
    assign c_load = b_valid_reg && c_rdy;
    assign d_load = c_valid_reg && d_rdy;
    assign e_load = d_valid_reg && e_rdy;

    assign a_valid_next = a_load || (a_valid_reg && !b_rdy);
    assign b_valid_next = b_load || (b_valid_reg && !c_rdy);
    assign c_valid_next = c_load || (c_valid_reg && !d_rdy);
    assign d_valid_next = d_load || (d_valid_reg && !e_rdy);
    assign m_valid_next = e_load || (m_valid_reg && !m_ready);

    assign cfg_ready = 1'b1;

    // error, saturating error sum and derivative difference
    always_comb begin
        b_err_next = $signed({setpoint_reg[31], setpoint_reg})
                   - $signed({a_meas_reg[31], a_meas_reg});
        sum_wide = $signed({error_sum_reg[pidff_pkg::SUM_W-1], error_sum_reg})
                 + $signed({{(pidff_pkg::SUM_W + 1 - pidff_pkg::ERR_W){b_err_next[32]}},
                            b_err_next});
        sum_ovf = sum_wide[pidff_pkg::SUM_W] != sum_wide[pidff_pkg::SUM_W-1];
        if (sum_ovf) begin
            error_sum_next = sum_wide[pidff_pkg::SUM_W] ? pidff_pkg::SUM_MIN
                                                        : pidff_pkg::SUM_MAX;
        end else begin
            error_sum_next = sum_wide[pidff_pkg::SUM_W-1:0];
        end
        b_sat_next = sum_ovf;
        if (first_sample_reg) begin
            b_diff_next = '0;
        end else begin
            b_diff_next = $signed({b_err_next[32], b_err_next})
                        - $signed({last_error_reg[32], last_error_reg});
        end
    end

    // gain products, integral product split into two halves of the sum
    always_comb begin
        c_pkp_next  = kp_reg * b_err_reg;
        c_pkd_next  = kd_rate_reg * b_diff_reg;
        c_pkih_next = ki_step_reg * $signed(b_sum_reg[47:24]);
        c_pkil_next = ki_step_reg * $signed({1'b0, b_sum_reg[23:0]});
    end

    // partial sums; the offset enters scaled by 2^16 so the floor shift stays exact
    always_comb begin
        d_s1_next = $signed({{17{c_pkp_reg[64]}}, c_pkp_reg})
                  + $signed({{16{c_pkd_reg[65]}}, c_pkd_reg});
        d_s2_next = $signed({{2{c_pkih_reg[55]}}, c_pkih_reg, 24'b0})
                  + $signed({{25{c_pkil_reg[56]}}, c_pkil_reg})
                  + $signed({{34{ff_offset_reg[31]}}, ff_offset_reg, 16'b0});
    end

    // final add, shift by 16 and output clip
    always_comb begin
        acc = d_s1_reg + d_s2_reg;
        acc_in_range = (&acc[81:47]) || !(|acc[81:47]);
        if (acc_in_range) begin
            m_drive_next = acc[47:16];
        end else begin
            m_drive_next = acc[81] ? pidff_pkg::DRIVE_MIN : pidff_pkg::DRIVE_MAX;
        end
        m_sat_next = d_sat_reg || !acc_in_range;
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= '0;
            kp_reg        <= '0;
            ki_step_reg   <= '0;
            kd_rate_reg   <= '0;
            ff_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pidff_pkg::REG_SETPOINT:  setpoint_reg  <= cfg_data;
                pidff_pkg::REG_KP:        kp_reg        <= cfg_data;
                pidff_pkg::REG_KI_STEP:   ki_step_reg   <= cfg_data;
                pidff_pkg::REG_KD_RATE:   kd_rate_reg   <= cfg_data;
                pidff_pkg::REG_FF_OFFSET: ff_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state: valids and controller history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            error_sum_reg    <= '0;
            last_error_reg   <= '0;
            first_sample_reg <= 1'b1;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
            m_valid_reg <= m_valid_next;
            if (b_load) begin
                error_sum_reg    <= error_sum_next;
                last_error_reg   <= b_err_next;
                first_sample_reg <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_meas_reg <= s_measured_value;
        end
        if (b_load) begin
            b_err_reg  <= b_err_next;
            b_diff_reg <= b_diff_next;
            b_sum_reg  <= error_sum_next;
            b_sat_reg  <= b_sat_next;
        end
        if (c_load) begin
            c_pkp_reg  <= c_pkp_next;
            c_pkd_reg  <= c_pkd_next;
            c_pkih_reg <= c_pkih_next;
            c_pkil_reg <= c_pkil_next;
            c_sat_reg  <= b_sat_reg;
        end
        if (d_load) begin
            d_s1_reg  <= d_s1_next;
            d_s2_reg  <= d_s2_next;
            d_sat_reg <= c_sat_reg;
        end
        if (e_load) begin
            m_drive_reg <= m_drive_next;
            m_sat_reg   <= m_sat_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = m_drive_reg;
    assign m_saturated   = m_sat_reg;

    // checks
    `PIDFF_ASSERT_NEXT(a_first_cleared, b_load, !first_sample_reg,
        "first sample flag still set after an item passed the error stage")
    `PIDFF_ASSERT_NOW(a_sample_flows, (!m_valid || m_ready), s_ready,
        "input stalled although the result stage is free")
    `PIDFF_ASSERT_NOW(a_sum_clip, (b_valid_reg && b_sat_reg),
        (b_sum_reg == pidff_pkg::SUM_MAX || b_sum_reg == pidff_pkg::SUM_MIN),
        "error sum flagged as clipped but not at a limit")

endmodule

// ----- bench/pid_with_feedforward_offset_check.sv -----
// checker for the pid controller with feedforward offset: predicts every drive item
// from the sample and register traffic and compares it with the result channel
// depends on pidff_pkg
module pid_with_feedforward_offset_check
    import pidff_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  data_t      s_measured_value,
    input  logic       m_valid,
    input  logic       m_ready,
    input  data_t      m_drive_value,
    input  logic       m_saturated,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  data_t      cfg_data,
    output int         fail_count,
    output int         outstanding
);

    localparam int FRAC_W = 16;

    // wide enough for the exact sum of the three products
    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        data_t drive;
        logic  sat;
    } drive_item_t;

    drive_item_t drive_q[$];

    // controller registers and loop state as the block should hold them
    data_t setpoint_r;
    data_t kp_r;
    data_t ki_step_r;
    data_t kd_rate_r;
    data_t ff_offset_r;
    sum_t  err_sum;
    err_t  prev_err;
    logic  first_pending;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        err_t                  err;
        logic signed [SUM_W:0] sum_next;
        diff_t                 diff;
        wide_t                 acc;
        drive_item_t           want;
        drive_item_t           oldest;
        if (!aresetn) begin
            setpoint_r    = '0;
            kp_r          = '0;
            ki_step_r     = '0;
            kd_rate_r     = '0;
            ff_offset_r   = '0;
            err_sum       = '0;
            prev_err      = '0;
            first_pending = 1'b1;
            drive_q.delete();
            outstanding  <= 0;
        end else begin
            // register writes, unmapped indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SETPOINT:  setpoint_r  = cfg_data;
                    REG_KP:        kp_r        = cfg_data;
                    REG_KI_STEP:   ki_step_r   = cfg_data;
                    REG_KD_RATE:   kd_rate_r   = cfg_data;
                    REG_FF_OFFSET: ff_offset_r = cfg_data;
                    default: ;
                endcase
            end

            // compare each result item with the oldest prediction
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    $error("result item with nothing expected: drive_value %0d",
                           m_drive_value);
                    fail_count++;
                end else begin
                    oldest = drive_q.pop_front();
                    if (m_drive_value !== oldest.drive) begin
                        $error("drive_value: expected %0d, actual %0d",
                               $signed(oldest.drive), m_drive_value);
                        fail_count++;
                    end
                    if (m_saturated !== oldest.sat) begin
                        $error("saturated: expected %0b, actual %0b",
                               oldest.sat, m_saturated);
                        fail_count++;
                    end
                end
            end

            // predict the drive for each accepted sample item
            if (s_valid && s_ready) begin
                err = {setpoint_r[DATA_W-1], setpoint_r}
                    - {s_measured_value[DATA_W-1], s_measured_value};
                want.sat = 1'b0;

                // saturating error sum
                sum_next = {err_sum[SUM_W-1], err_sum}
                         + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
                if (sum_next[SUM_W] != sum_next[SUM_W-1]) begin
                    err_sum  = sum_next[SUM_W] ? SUM_MIN : SUM_MAX;
                    want.sat = 1'b1;
                end else begin
                    err_sum = sum_next[SUM_W-1:0];
                end

                // no derivative on the first sample after reset
                diff = first_pending ? '0
                     : {err[ERR_W-1], err} - {prev_err[ERR_W-1], prev_err};
                first_pending = 1'b0;
                prev_err      = err;

                // exact products, floor shift, then the offset
                acc = wide_t'(kp_r) * wide_t'(err)
                    + wide_t'(ki_step_r) * wide_t'(err_sum)
                    + wide_t'(kd_rate_r) * wide_t'(diff);
                acc = (acc >>> FRAC_W) + wide_t'(ff_offset_r);

                // clip to the output range
                if (acc > wide_t'(DRIVE_MAX)) begin
                    want.drive = DRIVE_MAX;
                    want.sat   = 1'b1;
                end else if (acc < wide_t'(DRIVE_MIN)) begin
                    want.drive = DRIVE_MIN;
                    want.sat   = 1'b1;
                end else begin
                    want.drive = acc[DATA_W-1:0];
                end
                drive_q.push_back(want);
            end

            outstanding <= drive_q.size();
        end
    end

endmodule

// ----- bench/pid_with_feedforward_offset_test.sv -----
// top of the pid controller with feedforward offset bench: clock, reset, sample and
// register stimulus, result channel back-pressure, watchdog and verdict
// depends on pidff_pkg, pid_with_feedforward_offset and pid_with_feedforward_offset_check
module pid_with_feedforward_offset_test;
    import pidff_pkg::*;

    localparam int         HOLD_CYCLES   = 200;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         RANDOM_PHASES = 8;
    localparam int         PHASE_ITEMS   = 200;
    localparam int         DRAIN_CYCLES  = 20;
    localparam cfg_index_t REG_UNMAPPED  = REG_FF_OFFSET + 3'd1;
    localparam data_t      Q_ONE         = 32'sh0001_0000;

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    data_t      s_measured_value = '0;
    logic       m_ready          = 1'b0;
    logic       cfg_valid        = 1'b0;
    cfg_index_t cfg_index        = REG_SETPOINT;
    data_t      cfg_data         = '0;

    logic  s_ready;
    logic  m_valid;
    data_t m_drive_value;
    logic  m_saturated;
    logic  cfg_ready;

    int fail_count;
    int outstanding;

    // traffic shaping shared with the receiver process
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_done      = 1'b0;
    int   quiet_cycles   = 0;

    int idle_tab[4]  = '{0, 81, 0, 21};
    int stall_tab[4] = '{0, 0, 81, 21};

    data_t sp_now;

    always #4 aclk = ~aclk;

    pid_with_feedforward_offset u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_value (s_measured_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_value    (m_drive_value),
        .m_saturated      (m_saturated),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    pid_with_feedforward_offset_check u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_value (s_measured_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_value    (m_drive_value),
        .m_saturated      (m_saturated),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // random gain or setpoint over many magnitudes, extremes now and then
    function automatic data_t scaled_word();
        case ($urandom_range(15))
            0:       return DRIVE_MAX;
            1:       return DRIVE_MIN;
            2:       return '0;
            default: return data_t'($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    // offer one sample item, with a random gap first, and wait for acceptance
    task automatic send_sample(input data_t value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid          <= 1'b1;
        s_measured_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input cfg_index_t idx, input data_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_gains(input data_t sp, input data_t kp, input data_t ki,
                              input data_t kd, input data_t ff);
        sp_now = sp;
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_KP, kp);
        write_reg(REG_KI_STEP, ki);
        write_reg(REG_KD_RATE, kd);
        write_reg(REG_FF_OFFSET, ff);
    endtask

    // stop sending and wait until every predicted drive item has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // receiver: random stalls, and one long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        int    mode;
        data_t meas;
        sp_now = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first sample after reset: only the derivative gain is set
        write_reg(REG_KD_RATE, Q_ONE);
        send_sample(32'sh0003_0000);
        send_sample(Q_ONE);
        wait_drained();

        // moderate gains, and a write to an unmapped index that must be dropped
        load_gains(Q_ONE, 32'sh0002_0000, 32'sh0000_8000, Q_ONE, 32'sh0000_4000);
        write_reg(REG_UNMAPPED, DRIVE_MAX);
        send_sample('0);
        send_sample(DRIVE_MAX);
        send_sample(DRIVE_MIN);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(Q_ONE);
        send_sample(Q_ONE);
        send_sample(32'sh0002_0000);
        wait_drained();

        // all registers at the top of the range: output clips high
        load_gains(DRIVE_MAX, DRIVE_MAX, DRIVE_MAX, DRIVE_MAX, DRIVE_MAX);
        send_sample(DRIVE_MIN);
        send_sample(DRIVE_MAX);
        send_sample('0);
        wait_drained();

        // all registers at the bottom of the range
        load_gains(DRIVE_MIN, DRIVE_MIN, DRIVE_MIN, DRIVE_MIN, DRIVE_MIN);
        send_sample(DRIVE_MAX);
        send_sample(DRIVE_MIN);
        send_sample('0);
        wait_drained();

        // offset only
        load_gains('0, '0, '0, '0, DRIVE_MIN);
        send_sample('0);
        send_sample(32'sd5);
        wait_drained();

        // smallest proportional gain: the shift rounds toward minus infinity
        write_reg(REG_KP, 32'sd1);
        write_reg(REG_FF_OFFSET, '0);
        send_sample(32'sd1);
        send_sample(-32'sd1);
        send_sample(32'sd3);
        wait_drained();

        // random phases, each with fresh registers and the idling mode of phase % 4
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            mode = phase % 4;
            load_gains(scaled_word(), scaled_word(), scaled_word(), scaled_word(),
                       scaled_word());
            write_reg(cfg_index_t'(REG_UNMAPPED + $urandom_range(2)), data_t'($urandom));
            send_idle_pct   = idle_tab[mode];
            recv_stall_pct <= stall_tab[mode];
            // one long receiver hold-off while the sender keeps offering items
            if (phase == 4)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(9))
                    0:       meas = $urandom_range(1) ? DRIVE_MAX : DRIVE_MIN;
                    1, 2, 3: meas = data_t'($urandom);
                    default: meas = sp_now + (data_t'($urandom) >>> $urandom_range(31, 8));
                endcase
                send_sample(meas);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
